### rtl/mrps_pkg.sv
`default_nettype none
package mrps_pkg;
    localparam int NODES      = 16;
    localparam int NODE_W     = 4;
    localparam int EDGES      = 64;
    localparam int EDGE_AW    = 6;
    localparam int CNT_W      = 7;
    localparam int FRAC_BITS  = 16;
    localparam int REL_W      = FRAC_BITS + 1;
    localparam logic [REL_W-1:0] REL_ONE = REL_W'(1) << FRAC_BITS;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [REL_W-1:0]  rel;
    } edge_t;
endpackage
`default_nettype wire

### rtl/max_reliability_path_search.sv
// Clear and add complete in the idle state; a query first clears the node state, then
// for each taken node scans the node memory and then the edge table (each edge leaving
// that node goes through an update step), then walks the path and emits one beat per path node.
// The node and edge memories each have one synchronous read port and one write port.
// One beat is worked on at a time; results drain through a one-deep output register.
// Reset (rst_n, asynchronous, low) empties the edge table and overflow flag.
`default_nettype none
module max_reliability_path_search
    import mrps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        cmd,
    input  wire logic [3:0]        edge_source,
    input  wire logic [3:0]        edge_target,
    input  wire logic [16:0]       edge_reliability,
    input  wire logic [3:0]        start_node,
    input  wire logic [3:0]        end_node,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [3:0]             path_node,
    output logic                   last_of_path,
    output logic                   table_overflow
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_INIT  = 8'b00000010,
        S_SCAN  = 8'b00000100,
        S_EDGE  = 8'b00001000,
        S_UPD   = 8'b00010000,
        S_WALK  = 8'b00100000,
        S_WWAIT = 8'b01000000,
        S_EMIT  = 8'b10000000
    } state_t;

    state_t state_reg;

    // Edge table memory, synchronous read.
    edge_t edge_mem [EDGES];
    logic [EDGE_AW-1:0] edge_raddr;
    edge_t edge_rd;
    logic [CNT_W-1:0] count_reg;
    logic ovf_reg;

    logic [NODE_W-1:0] start_reg, end_reg;
    logic [NODES-1:0]  visited_reg;
    logic [NODE_W:0]   idx_reg;       // node scan / init counter
    logic [CNT_W-1:0]  eidx_reg;
    logic [NODE_W-1:0] pick_reg;
    logic [REL_W-1:0]  top_reg;
    logic              found_reg;
    logic [REL_W-1:0]  pick_rel_reg;
    logic [REL_W-1:0]  prod_reg;
    logic [NODE_W-1:0] dst_reg;
    logic              rd_pend_reg;   // node or edge memory read issued last cycle
    logic [NODE_W-1:0] rd_addr_reg;
    logic              scan_done_reg;

    logic [NODE_W-1:0] stack_mem [NODES];
    logic [NODE_W:0]   len_reg;
    logic [NODE_W-1:0] cur_reg;

    logic              nr_we;
    logic [NODE_W-1:0] nr_waddr, nr_raddr;
    logic [REL_W-1:0]  nr_wrel, nr_rrel;
    logic [NODE_W:0]   nr_wpred, nr_rpred;

    mrps_node_ram u_node_ram (
        .clk   (clk),
        .we    (nr_we),
        .waddr (nr_waddr),
        .wrel  (nr_wrel),
        .wpred (nr_wpred),
        .raddr (nr_raddr),
        .rrel  (nr_rrel),
        .rpred (nr_rpred)
    );

    logic out_free;
    assign out_free = !out_valid || out_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    // A path beat is loaded into the output register in this cycle.
    logic emit_fire;
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    logic accept;
    assign accept = in_valid && in_ready;

    logic [REL_W-1:0] sat_rel;
    assign sat_rel = (edge_reliability > REL_ONE) ? REL_ONE : edge_reliability;

    // Edge memory write and read.
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_ADD && count_reg < CNT_W'(EDGES))
        begin
            edge_mem[count_reg[EDGE_AW-1:0]] <= '{src: edge_source, dst: edge_target,
                                                 rel: sat_rel};
        end
        edge_rd <= edge_mem[edge_raddr];
    end
    assign edge_raddr = eidx_reg[EDGE_AW-1:0];

    logic [2*REL_W-1:0] mult;
    assign mult = pick_rel_reg * edge_rd.rel;

    // Node ram port control.
    always_comb
    begin
        nr_we    = 1'b0;
        nr_waddr = '0;
        nr_wrel  = '0;
        nr_wpred = {1'b1, {NODE_W{1'b0}}};
        nr_raddr = idx_reg[NODE_W-1:0];
        case (state_reg)
            S_INIT:
            begin
                nr_we    = 1'b1;
                nr_waddr = idx_reg[NODE_W-1:0];
                nr_wrel  = (idx_reg[NODE_W-1:0] == start_reg) ? REL_ONE : '0;
            end
            S_EDGE:  nr_raddr = edge_rd.dst;
            S_UPD:
            begin
                nr_we    = (prod_reg > nr_rrel);
                nr_waddr = dst_reg;
                nr_wrel  = prod_reg;
                nr_wpred = {1'b0, pick_reg};
            end
            S_WALK, S_WWAIT: nr_raddr = cur_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            out_valid      <= 1'b0;
            idx_reg        <= '0;
            eidx_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            scan_done_reg  <= 1'b0;
            visited_reg    <= '0;
            len_reg        <= '0;
        end
        else
        begin
            if (emit_fire)
                out_valid <= 1'b1;
            else if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (cmd)
                            CMD_CLEAR:
                            begin
                                count_reg <= '0;
                                ovf_reg   <= 1'b0;
                            end
                            CMD_ADD:
                            begin
                                if (count_reg < CNT_W'(EDGES))
                                    count_reg <= count_reg + 1'b1;
                                else
                                    ovf_reg <= 1'b1;
                            end
                            CMD_QUERY:
                            begin
                                start_reg   <= start_node;
                                end_reg     <= end_node;
                                idx_reg     <= '0;
                                visited_reg <= '0;
                                state_reg   <= S_INIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_INIT:
                begin
                    if (idx_reg == (NODE_W+1)'(NODES - 1))
                    begin
                        idx_reg       <= '0;
                        rd_pend_reg   <= 1'b0;
                        found_reg     <= 1'b0;
                        top_reg       <= '0;
                        scan_done_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_SCAN:
                begin
                    // Read node idx this cycle, compare the previous read.
                    rd_pend_reg <= !scan_done_reg;
                    rd_addr_reg <= idx_reg[NODE_W-1:0];
                    if (rd_pend_reg && !visited_reg[rd_addr_reg] && nr_rrel > top_reg)
                    begin
                        top_reg   <= nr_rrel;
                        pick_reg  <= rd_addr_reg;
                        found_reg <= 1'b1;
                    end
                    if (!scan_done_reg)
                    begin
                        if (idx_reg == (NODE_W+1)'(NODES - 1))
                            scan_done_reg <= 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!rd_pend_reg)
                    begin
                        // The last node's compare has landed; decide now.
                        if (!found_reg)
                        begin
                            cur_reg   <= end_reg;
                            len_reg   <= '0;
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            visited_reg[pick_reg] <= 1'b1;
                            pick_rel_reg          <= top_reg;
                            if (pick_reg == end_reg)
                            begin
                                cur_reg   <= end_reg;
                                len_reg   <= '0;
                                state_reg <= S_WALK;
                            end
                            else
                            begin
                                eidx_reg  <= '0;
                                state_reg <= S_EDGE;
                            end
                        end
                    end
                end
                S_EDGE:
                begin
                    // edge_rd holds entry eidx_reg - 1 while rd_pend_reg is set.
                    if (rd_pend_reg && edge_rd.src == pick_reg)
                    begin
                        prod_reg    <= mult[FRAC_BITS +: REL_W];
                        dst_reg     <= edge_rd.dst;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_UPD;
                    end
                    else if (eidx_reg >= count_reg)
                    begin
                        idx_reg       <= '0;
                        rd_pend_reg   <= 1'b0;
                        found_reg     <= 1'b0;
                        top_reg       <= '0;
                        scan_done_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        eidx_reg    <= eidx_reg + 1'b1;
                    end
                end
                S_UPD:
                begin
                    // Node ram holds dst's value; write back if better.
                    if (eidx_reg >= count_reg)
                    begin
                        idx_reg       <= '0;
                        rd_pend_reg   <= 1'b0;
                        found_reg     <= 1'b0;
                        top_reg       <= '0;
                        scan_done_reg <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        eidx_reg    <= eidx_reg + 1'b1;
                        state_reg   <= S_EDGE;
                    end
                end
                S_WALK:
                begin
                    state_reg <= S_WWAIT;
                end
                S_WWAIT:
                begin
                    stack_mem[len_reg[NODE_W-1:0]] <= cur_reg;
                    len_reg <= len_reg + 1'b1;
                    if (nr_rpred[NODE_W] || len_reg == (NODE_W+1)'(NODES - 1))
                        state_reg <= S_EMIT;
                    else
                    begin
                        cur_reg   <= nr_rpred[NODE_W-1:0];
                        state_reg <= S_WALK;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        path_node      <= stack_mem[len_reg[NODE_W-1:0] - 1'b1];
                        last_of_path   <= (len_reg == (NODE_W+1)'(1));
                        table_overflow <= ovf_reg;
                        len_reg        <= len_reg - 1'b1;
                        if (len_reg == (NODE_W+1)'(1))
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/mrps_node_ram.sv
`default_nettype none
// Per-node search state: best reliability and predecessor, one read port
// with registered data and one write port.
module mrps_node_ram
    import mrps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [NODE_W-1:0] waddr,
    input  wire logic [REL_W-1:0]  wrel,
    input  wire logic [NODE_W:0]   wpred,
    input  wire logic [NODE_W-1:0] raddr,
    output logic      [REL_W-1:0]  rrel,
    output logic      [NODE_W:0]   rpred
);
    logic [REL_W-1:0] rel_mem [NODES];
    logic [NODE_W:0]  pred_mem [NODES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rel_mem[waddr]  <= wrel;
            pred_mem[waddr] <= wpred;
        end
        rrel  <= rel_mem[raddr];
        rpred <= pred_mem[raddr];
    end
endmodule
`default_nettype wire
